// ----- design/wmm_pkg.sv -----
// Shared types, constants and helpers for the wildcard mask match unit.
// No dependencies; used by wmm_cell, wildcard_mask_match_unit, wmm_checker and testbench.
package wmm_pkg;

    localparam int MASK_MAX_DEF = 64;
    localparam int LEN_W        = 7;

    localparam logic [7:0] STAR    = 8'h2A;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_MASK   = 2'd1;
    localparam logic [1:0] FUNC_STRING = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    typedef struct packed {
        logic             mask_wr;
        logic             str_step;
        logic             str_restart;
        logic             case_sens;
        logic             is_suffix;
        logic             is_substr;
        logic             is_prefix;
        logic             is_exact;
        logic [LEN_W-1:0] mask_len;
        logic [LEN_W-1:0] str_cnt;
        logic [7:0]       data;
        logic [7:0]       data_fold;
    } cell_ctl_t;

    typedef struct packed {
        logic sub_hit;
        logic tail_hit;
        logic pre_miss;
    } cell_stat_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
        logic [7:0] r;
        r = b;
        if (!cs && b >= UPPER_A && b <= UPPER_Z)
        begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ----- design/wmm_cell.sv -----
// One cell of the match row: holds one mask byte and one match-vector bit.
// Depends on wmm_pkg.
module wmm_cell #(
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wmm_pkg::cell_ctl_t     ctl,
    input  logic                   chain_in,
    output logic                   chain_out,
    output wmm_pkg::cell_stat_t    stat
);
    import wmm_pkg::*;

    localparam logic [LEN_W-1:0] POS  = LEN_W'(IDX);
    localparam logic [LEN_W-1:0] POS1 = LEN_W'(IDX + 1);
    localparam logic [LEN_W-1:0] POS2 = LEN_W'(IDX + 2);
    localparam bit               HAS_VEC = (IDX != 0);

    logic [7:0] mask_byte_reg;
    logic       vec_reg;
    logic       vec_next;
    logic       eq;
    logic       win;
    logic       pre_lim;

    always_ff @(posedge clk)
    begin
        if (ctl.mask_wr && ctl.mask_len == POS)
        begin
            mask_byte_reg <= ctl.data;
        end
    end

    always_comb
    begin
        eq  = (fold_byte(mask_byte_reg, ctl.case_sens) == ctl.data_fold);
        win = HAS_VEC && ((ctl.is_suffix && POS < ctl.mask_len)
                       || (ctl.is_substr && POS1 < ctl.mask_len));
        pre_lim = (ctl.is_prefix && POS1 < ctl.mask_len)
               || (ctl.is_exact && POS < ctl.mask_len);
        if (ctl.str_restart)
        begin
            vec_next = 1'b0;
        end
        else if (ctl.str_step)
        begin
            vec_next = chain_in && eq && win;
        end
        else
        begin
            vec_next = vec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= 1'b0;
        end
        else
        begin
            vec_reg <= vec_next;
        end
    end

    assign chain_out     = vec_reg;
    assign stat.sub_hit  = HAS_VEC && ctl.str_step && vec_next && ctl.is_substr
                           && POS2 == ctl.mask_len;
    assign stat.tail_hit = vec_reg && POS1 == ctl.mask_len;
    assign stat.pre_miss = (ctl.str_cnt == POS) && !eq && pre_lim;

endmodule

// ----- design/wildcard_mask_match_unit.sv -----
// Top level of the wildcard mask match unit: control, row of match cells, result register.
// Depends on wmm_pkg and wmm_cell.
//
// Takes one beat per clock on the input channel, back to back, as long as the result
// register is free or being drained. Each string byte is compared against all mask bytes
// at once across the cell row and the match vector shifts one cell along. An end-of-string
// beat produces its result in the result register on the next cycle. The mask store lives
// in the cells (MASK_MAX bytes) and needs no clearing after reset. Case sensitivity is
// written through the cfg channel, always ready.
module wildcard_mask_match_unit #(
    parameter int MASK_MAX = wmm_pkg::MASK_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       mask_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import wmm_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MASK_MAX);
    localparam logic [LEN_W-1:0] COUNT_SAT = LEN_W'(MASK_MAX + 1);
    localparam logic [LEN_W-1:0] ONE       = LEN_W'(1);
    localparam logic [LEN_W-1:0] TWO       = LEN_W'(2);

    logic             case_sens_reg;
    logic [LEN_W-1:0] mask_len_reg,  mask_len_next;
    logic             mask_ovf_reg,  mask_ovf_next;
    logic             first_star_reg, first_star_next;
    logic             last_star_reg, last_star_next;
    logic [LEN_W-1:0] str_cnt_reg,   str_cnt_next;
    logic             pre_eq_reg,    pre_eq_next;
    logic             sub_seen_reg,  sub_seen_next;
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg,   matched_next;
    logic             mask_error_reg, mask_error_next;

    logic       acc;
    logic       nz;
    logic       is_all, is_suffix, is_substr, is_prefix, is_exact;
    logic       any_sub_hit, any_tail_hit, any_pre_miss;
    logic       verdict;
    cell_ctl_t  ctl;

    logic [MASK_MAX-1:0] vec;
    cell_stat_t          stat [MASK_MAX];

    assign acc       = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign nz        = (data_byte != 8'd0);

    always_comb
    begin
        is_all    = (mask_len_reg == ONE) && first_star_reg;
        is_suffix = (mask_len_reg != '0) && first_star_reg && !last_star_reg;
        is_prefix = (mask_len_reg != '0) && !first_star_reg && last_star_reg;
        is_substr = (mask_len_reg != '0) && first_star_reg && last_star_reg && !is_all;
        is_exact  = (mask_len_reg != '0) && !first_star_reg && !last_star_reg;
    end

    always_comb
    begin
        ctl             = '0;
        ctl.case_sens   = case_sens_reg;
        ctl.is_suffix   = is_suffix;
        ctl.is_substr   = is_substr;
        ctl.is_prefix   = is_prefix;
        ctl.is_exact    = is_exact;
        ctl.mask_len    = mask_len_reg;
        ctl.str_cnt     = str_cnt_reg;
        ctl.data        = data_byte;
        ctl.data_fold   = fold_byte(data_byte, case_sens_reg);
        if (acc)
        begin
            unique case (func)
                FUNC_CLEAR:
                begin
                    ctl.str_restart = 1'b1;
                end
                FUNC_MASK:
                begin
                    ctl.mask_wr     = nz && (mask_len_reg < LEN_MAX);
                    ctl.str_restart = nz;
                end
                FUNC_STRING:
                begin
                    ctl.str_step = nz;
                end
                FUNC_END:
                begin
                    ctl.str_restart = 1'b1;
                end
                default:
                begin
                    ctl.str_restart = 1'b0;
                end
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < MASK_MAX; k++)
        begin : g_cell
            logic cin;
            if (k == 0)
            begin : g_head
                assign cin = 1'b0;
            end
            else if (k == 1)
            begin : g_first
                assign cin = 1'b1;
            end
            else
            begin : g_rest
                assign cin = vec[k-1];
            end
            wmm_cell #(
                .IDX (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .chain_in  (cin),
                .chain_out (vec[k]),
                .stat      (stat[k])
            );
        end
    endgenerate

    always_comb
    begin
        any_sub_hit  = 1'b0;
        any_tail_hit = 1'b0;
        any_pre_miss = 1'b0;
        for (int i = 0; i < MASK_MAX; i++)
        begin
            any_sub_hit  = any_sub_hit  | stat[i].sub_hit;
            any_tail_hit = any_tail_hit | stat[i].tail_hit;
            any_pre_miss = any_pre_miss | stat[i].pre_miss;
        end
    end

    always_comb
    begin
        verdict = 1'b0;
        if (is_all)
        begin
            verdict = 1'b1;
        end
        else if (is_suffix)
        begin
            verdict = any_tail_hit;
        end
        else if (is_prefix)
        begin
            verdict = (str_cnt_reg >= mask_len_reg - ONE) && pre_eq_reg;
        end
        else if (is_substr)
        begin
            verdict = (mask_len_reg == TWO) || sub_seen_reg;
        end
        else if (is_exact)
        begin
            verdict = (str_cnt_reg == mask_len_reg) && pre_eq_reg;
        end
    end

    always_comb
    begin
        mask_len_next   = mask_len_reg;
        mask_ovf_next   = mask_ovf_reg;
        first_star_next = first_star_reg;
        last_star_next  = last_star_reg;
        str_cnt_next    = str_cnt_reg;
        pre_eq_next     = pre_eq_reg;
        sub_seen_next   = sub_seen_reg;
        matched_next    = matched_reg;
        mask_error_next = mask_error_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (acc && func == FUNC_CLEAR)
        begin
            mask_len_next = '0;
            mask_ovf_next = 1'b0;
        end
        if (ctl.mask_wr)
        begin
            mask_len_next  = mask_len_reg + ONE;
            last_star_next = (data_byte == STAR);
            if (mask_len_reg == '0)
            begin
                first_star_next = (data_byte == STAR);
            end
        end
        else if (acc && func == FUNC_MASK && nz)
        begin
            mask_ovf_next = 1'b1;
        end
        if (acc && func == FUNC_END)
        begin
            out_valid_next  = 1'b1;
            matched_next    = !mask_ovf_reg && verdict;
            mask_error_next = mask_ovf_reg;
        end
        if (ctl.str_restart)
        begin
            str_cnt_next  = '0;
            pre_eq_next   = 1'b1;
            sub_seen_next = 1'b0;
        end
        else if (ctl.str_step)
        begin
            if (str_cnt_reg < COUNT_SAT)
            begin
                str_cnt_next = str_cnt_reg + ONE;
            end
            if (any_pre_miss)
            begin
                pre_eq_next = 1'b0;
            end
            if (any_sub_hit)
            begin
                sub_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sens_reg  <= 1'b1;
            mask_len_reg   <= '0;
            mask_ovf_reg   <= 1'b0;
            first_star_reg <= 1'b0;
            last_star_reg  <= 1'b0;
            str_cnt_reg    <= '0;
            pre_eq_reg     <= 1'b1;
            sub_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case_sens_reg <= cfg_data;
            end
            mask_len_reg   <= mask_len_next;
            mask_ovf_reg   <= mask_ovf_next;
            first_star_reg <= first_star_next;
            last_star_reg  <= last_star_next;
            str_cnt_reg    <= str_cnt_next;
            pre_eq_reg     <= pre_eq_next;
            sub_seen_reg   <= sub_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg    <= matched_next;
        mask_error_reg <= mask_error_next;
    end

    assign out_valid  = out_valid_reg;
    assign matched    = matched_reg;
    assign mask_error = mask_error_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mask_len_reg <= LEN_MAX)
        else $error("mask length beyond store");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        mask_ovf_reg |-> (mask_len_reg == LEN_MAX))
        else $error("overflow flagged with store not full");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        str_cnt_reg <= COUNT_SAT)
        else $error("string count beyond saturation");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && func == FUNC_END) |=> (out_valid && (!mask_error || !matched)))
        else $error("end beat did not yield a consistent result");

endmodule

// ----- bench/wmm_checker.sv -----
// Checker for the wildcard mask match unit: watches the input, config and result channels,
// predicts each end-of-string verdict from its own copy of the mask and string state, and compares.
// Depends on wmm_pkg; instantiated by testbench beside the unit.
`timescale 1ns / 100ps

module wmm_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       matched,
    input  logic       mask_error,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         fail_count,
    output int         outstanding
);
    import wmm_pkg::*;

    localparam int MASK_DEPTH = MASK_MAX_DEF;
    localparam int IDX_W      = $clog2(MASK_DEPTH);
    localparam int COUNT_SAT  = MASK_DEPTH + 1;

    typedef enum logic [2:0] {
        KIND_EMPTY,
        KIND_ALL,
        KIND_SUFFIX,
        KIND_PREFIX,
        KIND_SUBSTR,
        KIND_EXACT
    } mask_kind_t;

    typedef struct packed {
        logic matched;
        logic mask_error;
    } verdict_t;

    logic [7:0]  mask_bytes [MASK_DEPTH];
    logic [6:0]  mask_len;
    logic        mask_ovf;
    logic [63:0] hit_vec;
    logic [6:0]  str_len;
    logic        head_equal;
    logic        core_seen;
    logic        case_sens;

    verdict_t expected_verdicts[$];

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (!case_sens && b >= UPPER_A && b <= UPPER_Z)
        begin
            return b + CASE_OFS;
        end
        return b;
    endfunction

    function automatic mask_kind_t mask_kind();
        logic lead;
        logic trail;
        if (mask_len == 0)
        begin
            return KIND_EMPTY;
        end
        lead  = (mask_bytes[0] == STAR);
        trail = (mask_bytes[IDX_W'(mask_len - 7'd1)] == STAR);
        if (mask_len == 1 && lead)
        begin
            return KIND_ALL;
        end
        if (lead && !trail)
        begin
            return KIND_SUFFIX;
        end
        if (!lead && trail)
        begin
            return KIND_PREFIX;
        end
        if (lead && trail)
        begin
            return KIND_SUBSTR;
        end
        return KIND_EXACT;
    endfunction

    task automatic restart_string();
        hit_vec    = '0;
        str_len    = '0;
        head_equal = 1'b1;
        core_seen  = 1'b0;
    endtask

    task automatic take_string_byte(input logic [7:0] b);
        mask_kind_t  kind;
        logic [7:0]  c;
        logic [63:0] sel;
        int          n;
        int          m;
        int          lim;
        kind = mask_kind();
        c    = to_lower(b);
        n    = int'(mask_len);
        if (kind == KIND_SUFFIX || kind == KIND_SUBSTR)
        begin
            m   = (kind == KIND_SUFFIX) ? n - 1 : n - 2;
            sel = '0;
            for (int j = 0; j < m && j + 1 < MASK_DEPTH; j++)
            begin
                if (to_lower(mask_bytes[j + 1]) == c)
                begin
                    sel[j] = 1'b1;
                end
            end
            hit_vec = ((hit_vec << 1) | 64'd1) & sel;
            if (kind == KIND_SUBSTR && m > 0 && hit_vec[m - 1])
            begin
                core_seen = 1'b1;
            end
        end
        else if (kind == KIND_PREFIX || kind == KIND_EXACT)
        begin
            lim = (kind == KIND_PREFIX) ? n - 1 : n;
            if (int'(str_len) < lim && int'(str_len) < MASK_DEPTH
                && to_lower(mask_bytes[str_len[IDX_W-1:0]]) != c)
            begin
                head_equal = 1'b0;
            end
        end
        if (int'(str_len) < COUNT_SAT)
        begin
            str_len = str_len + 1'b1;
        end
    endtask

    function automatic logic judge_string();
        int n;
        n = int'(mask_len);
        case (mask_kind())
            KIND_ALL:    return 1'b1;
            KIND_SUFFIX: return hit_vec[(n - 2) & 63];
            KIND_PREFIX: return (int'(str_len) >= n - 1) && head_equal;
            KIND_SUBSTR: return (n == 2) || core_seen;
            KIND_EXACT:  return (int'(str_len) == n) && head_equal;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic predict_beat(input logic [1:0] f, input logic [7:0] b);
        verdict_t v;
        case (f)
            FUNC_CLEAR:
            begin
                mask_len = '0;
                mask_ovf = 1'b0;
                restart_string();
            end
            FUNC_MASK:
            begin
                if (b != 8'h00)
                begin
                    if (int'(mask_len) < MASK_DEPTH)
                    begin
                        mask_bytes[mask_len[IDX_W-1:0]] = b;
                        mask_len = mask_len + 1'b1;
                    end
                    else
                    begin
                        mask_ovf = 1'b1;
                    end
                    restart_string();
                end
            end
            FUNC_STRING:
            begin
                if (b != 8'h00)
                begin
                    take_string_byte(b);
                end
            end
            default:
            begin
                if (mask_ovf)
                begin
                    v.matched    = 1'b0;
                    v.mask_error = 1'b1;
                end
                else
                begin
                    v.matched    = judge_string();
                    v.mask_error = 1'b0;
                end
                expected_verdicts.push_back(v);
                restart_string();
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            mask_len   = '0;
            mask_ovf   = 1'b0;
            case_sens  = 1'b1;
            restart_string();
            expected_verdicts.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result beat matched=%0b mask_error=%0b",
                             $time, matched, mask_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (matched !== want.matched)
                    begin
                        $display("%0t: matched expected %0b actual %0b",
                                 $time, want.matched, matched);
                        fail_count++;
                    end
                    if (mask_error !== want.mask_error)
                    begin
                        $display("%0t: mask_error expected %0b actual %0b",
                                 $time, want.mask_error, mask_error);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_beat(func, data_byte);
            end
            if (cfg_valid && cfg_ready)
            begin
                case_sens = cfg_data;
            end
            outstanding = expected_verdicts.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the bench for the wildcard mask match unit: clock, reset, stimulus and verdict.
// Depends on wmm_pkg, wildcard_mask_match_unit and wmm_checker.
`timescale 1ns / 100ps

module testbench;
    import wmm_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASE_BEATS  = 500;
    localparam int HOLD_CYCLES  = 200;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic       matched;
    logic       mask_error;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    int fail_count;
    int outstanding;
    int beats_sent;
    int cycle_count;
    bit steady;
    bit sink_hold;
    bit case_sens_now;

    wildcard_mask_match_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .matched    (matched),
        .mask_error (mask_error),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    wmm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .matched     (matched),
        .mask_error  (mask_error),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!steady && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [1:0] f, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (!((f == FUNC_MASK || f == FUNC_STRING) && b == 8'h00))
        begin
            beats_sent++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_case_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case_sens_now = v;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'h61;
                1:       return 8'h62;
                2:       return UPPER_A;
                default: return 8'h42;
            endcase
        end
        if (r < 60)
        begin
            return STAR;
        end
        if (r < 75)
        begin
            // edges of the letter ranges
            case ($urandom_range(0, 7))
                0:       return UPPER_A - 8'd1;
                1:       return UPPER_A;
                2:       return UPPER_Z;
                3:       return UPPER_Z + 8'd1;
                4:       return UPPER_A + CASE_OFS - 8'd1;
                5:       return UPPER_A + CASE_OFS;
                6:       return UPPER_Z + CASE_OFS;
                default: return UPPER_Z + CASE_OFS + 8'd1;
            endcase
        end
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        logic letter;
        letter = (b >= UPPER_A && b <= UPPER_Z)
              || (b >= UPPER_A + CASE_OFS && b <= UPPER_Z + CASE_OFS);
        if (letter && !case_sens_now && $urandom_range(0, 1))
        begin
            return b ^ CASE_OFS;
        end
        return b;
    endfunction

    task automatic send_string(input logic [7:0] body[$]);
        foreach (body[i])
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                send_beat(FUNC_STRING, 8'h00);
            end
            if ($urandom_range(0, 59) == 0)
            begin
                send_beat(FUNC_MASK, pick_byte());
            end
            send_beat(FUNC_STRING, body[i]);
        end
    endtask

    task automatic send_sequence();
        logic [7:0] core[$];
        logic [7:0] body[$];
        bit [1:0]   stars;
        int         core_len;
        int         len;
        steady = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            return;
        end
        if ($urandom_range(0, 4) != 0)
        begin
            send_beat(FUNC_CLEAR, 8'($urandom_range(0, 255)));
        end
        core_len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 5);
        repeat (core_len) core.push_back(pick_byte());
        stars = 2'($urandom_range(0, 3));
        if (stars[0])
        begin
            send_beat(FUNC_MASK, STAR);
        end
        foreach (core[i])
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                send_beat(FUNC_MASK, 8'h00);
            end
            send_beat(FUNC_MASK, core[i]);
        end
        if (stars[1])
        begin
            send_beat(FUNC_MASK, STAR);
        end
        repeat ($urandom_range(1, 3))
        begin
            body.delete();
            if ($urandom_range(0, 1))
            begin
                len = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
                repeat (len) body.push_back(pick_byte());
                foreach (core[i])
                begin
                    body.push_back(flip_case(core[i]));
                end
                if ($urandom_range(0, 7) == 0 && body.size() > 0)
                begin
                    body[$urandom_range(0, body.size() - 1)] = pick_byte();
                end
                len = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
                repeat (len) body.push_back(pick_byte());
            end
            else
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
                repeat (len) body.push_back(pick_byte());
            end
            send_string(body);
            if ($urandom_range(0, 19) != 0)
            begin
                send_beat(FUNC_END, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_CLEAR;
        data_byte     = 8'h00;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        steady        = 1'b1;
        sink_hold     = 1'b0;
        case_sens_now = 1'b1;
        beats_sent    = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty mask, lone star, double star on an empty string
        send_beat(FUNC_END, 8'hFF);
        send_beat(FUNC_MASK, STAR);
        send_beat(FUNC_END, 8'h00);
        send_beat(FUNC_MASK, STAR);
        send_beat(FUNC_END, 8'h00);
        // prefix with a dropped zero byte
        send_beat(FUNC_CLEAR, 8'hFF);
        send_beat(FUNC_MASK, 8'h61);
        send_beat(FUNC_MASK, STAR);
        send_beat(FUNC_STRING, 8'h61);
        send_beat(FUNC_STRING, 8'h00);
        send_beat(FUNC_STRING, 8'h62);
        send_beat(FUNC_END, 8'h00);
        // mask byte mid-string restarts it; mask becomes exact "a*b"
        send_beat(FUNC_STRING, 8'h62);
        send_beat(FUNC_MASK, 8'h62);
        send_beat(FUNC_STRING, 8'h61);
        send_beat(FUNC_STRING, STAR);
        send_beat(FUNC_STRING, 8'h62);
        send_beat(FUNC_END, 8'h00);
        // suffix on the top byte value
        send_beat(FUNC_CLEAR, 8'h00);
        send_beat(FUNC_MASK, STAR);
        send_beat(FUNC_MASK, 8'hFF);
        send_beat(FUNC_STRING, 8'h7F);
        send_beat(FUNC_STRING, 8'hFF);
        send_beat(FUNC_END, 8'h00);
        steady = 1'b0;

        beats_sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            drain_results();
            write_case_mode(phase == 1);
            if (phase == 1)
            begin
                // long result-side hold while beats keep coming
                sink_hold = 1'b1;
                repeat (6)
                begin
                    send_sequence();
                    steady = 1'b1;
                    send_beat(FUNC_END, 8'h00);
                end
            end
            while (beats_sent < PHASE_BEATS * (phase + 1)) send_sequence();
        end

        drain_results();
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
